// ===== rtl/bfdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfdc_pkg
// Types, codes and helpers shared by the byte FIFO with delimiter count.
// ----------------------------------------------------------------------------
package bfdc_pkg;

	localparam int unsigned USABLE_CAPACITY_DEF = 255;

	typedef enum logic [2:0] {
		OP_PUT     = 3'd0,
		OP_GET     = 3'd1,
		OP_PEEK    = 3'd2,
		OP_DISCARD = 3'd3,
		OP_FLUSH   = 3'd4
	} op_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DISCARD,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data_in;
		logic [7:0] amount;
	} in_item_t;

	typedef struct packed {
		logic       accepted;
		logic [7:0] data_out;
		logic [7:0] dropped;
		logic [7:0] fill_level;
		logic [7:0] free_space;
		logic       is_empty;
		logic       is_full;
		logic [7:0] delimiter_count;
	} out_item_t;

	// saturating delimiter counter steps
	function automatic logic [7:0] count_up(input logic [7:0] cnt);
		count_up = (cnt == 8'hff) ? cnt : cnt + 8'd1;
	endfunction

	function automatic logic [7:0] count_down(input logic [7:0] cnt);
		count_down = (cnt == 8'h00) ? cnt : cnt - 8'd1;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/bfdc_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfdc_mem
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bfdc_mem #(
	parameter int unsigned DEPTH = bfdc_pkg::USABLE_CAPACITY_DEF + 1,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/byte_fifo_delimiter_count_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_fifo_delimiter_count_core
// Circular byte FIFO with one spare slot and a running count of stored
// delimiter bytes; one result beat per request beat.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------
//  in       | in_valid / in_ready  | in_item  (kind, data_in, amount)
//  out      | out_valid / out_ready| out_item (result and status)
//  cfg      | cfg_valid / cfg_ready| cfg_data (delimiter byte)
//
// put, flush, discard-as-flush, discard of zero bytes, empty get/peek and
// unused kinds: result registered in the cycle after the beat. get/peek:
// through ST_READ, for the registered read of the byte store. discard of
// n > 0 bytes below the fill level: ST_DISCARD then ST_DRAIN, one store read
// per dropped byte. A new beat is taken in idle once the result register is
// free or being emptied. No clearing pass after reset.
// ----------------------------------------------------------------------------
module byte_fifo_delimiter_count_core #(
	parameter int unsigned USABLE_CAPACITY = bfdc_pkg::USABLE_CAPACITY_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire bfdc_pkg::in_item_t  in_item,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output bfdc_pkg::out_item_t      out_item,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [7:0]          cfg_data
);

	localparam int unsigned SLOTS = USABLE_CAPACITY + 1;
	localparam int unsigned PW    = $clog2(SLOTS);
	localparam logic [PW:0]   SLOTS_W = (PW+1)'(SLOTS);
	localparam logic [PW-1:0] LAST_W  = PW'(SLOTS - 1);
	localparam logic [PW-1:0] CAP_W   = PW'(USABLE_CAPACITY);

	bfdc_pkg::state_t   state_q, state_d;
	bfdc_pkg::in_item_t item_q, item_d;

	logic [PW-1:0] rd_q, rd_d, wr_q, wr_d;
	logic [PW-1:0] rd_next, wr_next;
	logic [7:0]    cnt_q, cnt_d;
	logic [7:0]    rem_q, rem_d;
	logic [7:0]    delimiter_q;
	logic          out_valid_q, out_valid_d;
	logic          acc_q, acc_d;
	logic [7:0]    dout_q, dout_d;
	logic [7:0]    drop_q, drop_d;
	logic          rvalid_s1, issue;
	logic          mem_we;
	logic [7:0]    rdata;
	logic          dec_hit;

	logic [PW:0]   diff;
	logic [PW-1:0] fill, free;
	logic [PW+7:0] fill_x, free_x, amount_x;
	logic          empty, full;

	bfdc_mem #(
		.DEPTH (SLOTS),
		.AW    (PW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_q),
		.wdata (in_item.data_in),
		.raddr (rd_q),
		.rdata (rdata)
	);

	// positions and status
	assign rd_next  = (rd_q == LAST_W) ? '0 : rd_q + PW'(1);
	assign wr_next  = (wr_q == LAST_W) ? '0 : wr_q + PW'(1);
	assign diff     = {1'b0, wr_q} - {1'b0, rd_q};
	assign fill     = (wr_q >= rd_q) ? diff[PW-1:0] : PW'(diff + SLOTS_W);
	assign free     = CAP_W - fill;
	assign fill_x   = {8'd0, fill};
	assign free_x   = {8'd0, free};
	assign amount_x = {{PW{1'b0}}, in_item.amount};
	assign empty    = (rd_q == wr_q);
	assign full     = (rd_q == wr_next);

	assign dec_hit   = rvalid_s1 && (rdata == delimiter_q);
	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == bfdc_pkg::ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		out_item.accepted        = acc_q;
		out_item.data_out        = dout_q;
		out_item.dropped         = drop_q;
		out_item.fill_level      = fill_x[7:0];
		out_item.free_space      = free_x[7:0];
		out_item.is_empty        = empty;
		out_item.is_full         = full;
		out_item.delimiter_count = cnt_q;
	end

	always_comb begin
		state_d     = state_q;
		item_d      = item_q;
		rd_d        = rd_q;
		wr_d        = wr_q;
		cnt_d       = cnt_q;
		rem_d       = rem_q;
		out_valid_d = out_valid_q && !out_ready;
		acc_d       = acc_q;
		dout_d      = dout_q;
		drop_d      = drop_q;
		mem_we      = 1'b0;
		issue       = 1'b0;
		unique case (state_q)
			bfdc_pkg::ST_IDLE: begin
				if (in_valid && in_ready) begin
					item_d = in_item;
					acc_d  = 1'b0;
					dout_d = 8'd0;
					drop_d = 8'd0;
					unique case (in_item.kind)
						bfdc_pkg::OP_PUT: begin
							out_valid_d = 1'b1;
							if (!full) begin
								mem_we = 1'b1;
								wr_d   = wr_next;
								acc_d  = 1'b1;
								if (in_item.data_in == delimiter_q) begin
									cnt_d = bfdc_pkg::count_up(cnt_q);
								end
							end
						end
						bfdc_pkg::OP_GET, bfdc_pkg::OP_PEEK: begin
							if (empty) begin
								out_valid_d = 1'b1;
							end else begin
								state_d = bfdc_pkg::ST_READ;
							end
						end
						bfdc_pkg::OP_DISCARD: begin
							if (fill_x > amount_x) begin
								if (in_item.amount == 8'd0) begin
									out_valid_d = 1'b1;
								end else begin
									rem_d   = in_item.amount;
									state_d = bfdc_pkg::ST_DISCARD;
								end
							end else begin
								rd_d        = wr_q;
								cnt_d       = 8'd0;
								drop_d      = fill_x[7:0];
								out_valid_d = 1'b1;
							end
						end
						bfdc_pkg::OP_FLUSH: begin
							rd_d        = wr_q;
							cnt_d       = 8'd0;
							drop_d      = fill_x[7:0];
							out_valid_d = 1'b1;
						end
						default: begin
							out_valid_d = 1'b1;
						end
					endcase
				end
			end
			bfdc_pkg::ST_READ: begin
				// store data for the read position arrives this cycle
				acc_d       = 1'b1;
				dout_d      = rdata;
				out_valid_d = 1'b1;
				state_d     = bfdc_pkg::ST_IDLE;
				if (item_q.kind == bfdc_pkg::OP_GET) begin
					rd_d = rd_next;
					if (rdata == delimiter_q) begin
						cnt_d = bfdc_pkg::count_down(cnt_q);
					end
				end
			end
			bfdc_pkg::ST_DISCARD: begin
				// one read issued per cycle, each compared in the next cycle
				issue = 1'b1;
				rd_d  = rd_next;
				rem_d = rem_q - 8'd1;
				if (dec_hit) begin
					cnt_d = bfdc_pkg::count_down(cnt_q);
				end
				if (rem_q == 8'd1) begin
					state_d = bfdc_pkg::ST_DRAIN;
				end
			end
			bfdc_pkg::ST_DRAIN: begin
				if (dec_hit) begin
					cnt_d = bfdc_pkg::count_down(cnt_q);
				end
				drop_d      = item_q.amount;
				out_valid_d = 1'b1;
				state_d     = bfdc_pkg::ST_IDLE;
			end
			default: begin
				state_d = bfdc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bfdc_pkg::ST_IDLE;
			rd_q        <= '0;
			wr_q        <= '0;
			cnt_q       <= 8'd0;
			rem_q       <= 8'd0;
			out_valid_q <= 1'b0;
			rvalid_s1   <= 1'b0;
			delimiter_q <= 8'd0;
		end else begin
			state_q     <= state_d;
			rd_q        <= rd_d;
			wr_q        <= wr_d;
			cnt_q       <= cnt_d;
			rem_q       <= rem_d;
			out_valid_q <= out_valid_d;
			rvalid_s1   <= issue;
			if (cfg_valid && cfg_ready) begin
				delimiter_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_d;
		acc_q  <= acc_d;
		dout_q <= dout_d;
		drop_q <= drop_d;
	end

endmodule
`default_nettype wire
